FILE: design/rcpb_pkg.sv
// Package for the RC pulse to bridge drive block.
// Holds the payload structs, register and state codes, and the controller command bundle.
// No dependencies.
package rcpb_pkg;

  localparam int unsigned WidthBits = 16;
  localparam int unsigned DutyBits = 8;
  localparam int unsigned NumBits = WidthBits + DutyBits;
  localparam int unsigned DivSteps = DutyBits;
  localparam int unsigned StepBits = $clog2(DivSteps);

  localparam logic [WidthBits-1:0] NEUTRAL_RESET = 16'd1500;
  localparam logic [WidthBits-1:0] DEADBAND_RESET = 16'd50;
  localparam logic [WidthBits-1:0] MAX_RESET = 16'd2000;
  localparam logic [WidthBits-1:0] MIN_RESET = 16'd1000;
  localparam logic [WidthBits-1:0] WIDTH_RESET = 16'd1500;
  localparam logic [WidthBits-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [DutyBits-1:0] DUTY_FULL = 8'd255;
  localparam logic [DutyBits-1:0] DUTY_ZERO = 8'd0;

  typedef enum logic [1:0] {
    REG_NEUTRAL = 2'd0,
    REG_DEADBAND = 2'd1,
    REG_MAX = 2'd2,
    REG_MIN = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_DIV
  } duty_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_DIV,
    S_STORE,
    S_PUBLISH
  } state_t;

  typedef struct packed {
    logic left_level;
    logic right_level;
  } item_t;

  typedef struct packed {
    logic [DutyBits-1:0] left_fwd_duty;
    logic [DutyBits-1:0] left_rev_duty;
    logic [DutyBits-1:0] right_fwd_duty;
    logic [DutyBits-1:0] right_rev_duty;
  } result_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic load;
    logic step;
    logic store;
    logic publish;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic hold;
  } status_t;

endpackage

FILE: design/rcpb_ctrl.sv
// Controller state machine for the RC pulse to bridge drive block.
// Sequences tracking, the two shared divisions and the result transfer.
// Depends on rcpb_pkg.
module rcpb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  rcpb_pkg::status_t status,
  output rcpb_pkg::cmd_t   cmd
);
  import rcpb_pkg::*;

  state_t state;
  state_t state_next;
  logic ch;
  logic [StepBits-1:0] step;
  localparam logic [StepBits-1:0] LastStep = StepBits'(DivSteps - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (step == LastStep) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        if (ch) begin
          state_next = S_PUBLISH;
        end else begin
          state_next = S_PREP;
        end
      end
      S_PUBLISH: begin
        if (!status.hold) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != S_IDLE);
    cmd.accept = (state == S_IDLE) && item_valid;
    cmd.prep = (state == S_PREP);
    cmd.load = (state == S_LOAD);
    cmd.step = (state == S_DIV);
    cmd.store = (state == S_STORE);
    cmd.publish = (state == S_PUBLISH) && !status.hold;
    cmd.ch = ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch <= 1'b0;
      step <= '0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        ch <= 1'b0;
      end else if (cmd.store) begin
        ch <= ~ch;
      end
      if (cmd.load) begin
        step <= '0;
      end else if (cmd.step) begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

FILE: design/rcpb_datapath.sv
// Datapath for the RC pulse to bridge drive block.
// Holds the configuration, pulse trackers, shared restoring divider and result register.
// Depends on rcpb_pkg.
module rcpb_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [rcpb_pkg::WidthBits-1:0] cfg_data,
  input  rcpb_pkg::item_t            item,
  input  rcpb_pkg::cmd_t             cmd,
  output rcpb_pkg::status_t          status,
  output logic                       result_valid,
  input  logic                       result_stall,
  output rcpb_pkg::result_t          result
);
  import rcpb_pkg::*;

  logic [WidthBits-1:0] neutral_width;
  logic [WidthBits-1:0] deadband_width;
  logic [WidthBits-1:0] max_width;
  logic [WidthBits-1:0] min_width;

  logic [1:0] prev;
  logic [1:0] level;
  logic [WidthBits-1:0] count [2];
  logic [WidthBits-1:0] count_next [2];
  logic [WidthBits-1:0] width [2];
  logic [WidthBits-1:0] width_next [2];

  logic [WidthBits-1:0] x;
  logic [WidthBits:0] up;
  logic signed [WidthBits+1:0] dn;
  logic signed [WidthBits+1:0] den_s;
  logic is_fwd;
  logic is_rev;
  logic [WidthBits-1:0] mag_next;
  duty_mode_t mode_next;

  logic [WidthBits-1:0] mag;
  logic [WidthBits-1:0] den;
  logic dir_fwd;
  duty_mode_t mode;

  logic [NumBits-1:0] num;
  logic [WidthBits-1:0] rem;
  logic [DutyBits-1:0] num_lo;
  logic [DutyBits-1:0] quot;
  logic [WidthBits:0] rem_sh;
  logic rem_ge;
  logic [WidthBits:0] rem_diff;
  logic [DutyBits-1:0] duty;

  result_t res;

  assign level = {item.right_level, item.left_level};
  assign status.hold = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      neutral_width <= NEUTRAL_RESET;
      deadband_width <= DEADBAND_RESET;
      max_width <= MAX_RESET;
      min_width <= MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NEUTRAL: neutral_width <= cfg_data;
        REG_DEADBAND: deadband_width <= cfg_data;
        REG_MAX: max_width <= cfg_data;
        REG_MIN: min_width <= cfg_data;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      count_next[i] = count[i];
      width_next[i] = width[i];
      if (level[i] && !prev[i]) begin
        count_next[i] = '0;
      end else begin
        if (count[i] != COUNT_MAX) begin
          count_next[i] = count[i] + 1'b1;
        end
        if (!level[i] && prev[i]) begin
          width_next[i] = count_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
      for (int i = 0; i < 2; i++) begin
        count[i] <= '0;
        width[i] <= WIDTH_RESET;
      end
    end else if (cmd.accept) begin
      prev <= level;
      for (int i = 0; i < 2; i++) begin
        count[i] <= count_next[i];
        width[i] <= width_next[i];
      end
    end
  end

  always_comb begin
    x = width[cmd.ch];
    up = {1'b0, neutral_width} + {1'b0, deadband_width};
    dn = $signed({2'b00, neutral_width}) - $signed({2'b00, deadband_width});
    is_fwd = ({1'b0, x} > up);
    is_rev = ($signed({2'b00, x}) < dn);
    if (is_fwd) begin
      mag_next = x - up[WidthBits-1:0];
      den_s = $signed({2'b00, max_width}) - $signed({1'b0, up});
    end else begin
      mag_next = dn[WidthBits-1:0] - x;
      den_s = dn - $signed({2'b00, min_width});
    end
    if (!is_fwd && !is_rev) begin
      mode_next = MODE_ZERO;
    end else if (den_s == '0) begin
      mode_next = MODE_FULL;
    end else if (den_s[WidthBits+1]) begin
      mode_next = MODE_ZERO;
    end else begin
      mode_next = MODE_DIV;
    end
  end

  always_comb begin
    num = {mag, {DutyBits{1'b0}}} - {{DutyBits{1'b0}}, mag};
    rem_sh = {rem, num_lo[DutyBits-1]};
    rem_ge = (rem_sh >= {1'b0, den});
    rem_diff = rem_sh - {1'b0, den};
    unique case (mode)
      MODE_ZERO: duty = DUTY_ZERO;
      MODE_FULL: duty = DUTY_FULL;
      MODE_DIV: duty = quot;
      default: duty = DUTY_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mag <= mag_next;
      den <= den_s[WidthBits-1:0];
      dir_fwd <= is_fwd;
      mode <= mode_next;
    end
    if (cmd.load) begin
      rem <= num[NumBits-1:DutyBits];
      num_lo <= num[DutyBits-1:0];
      quot <= '0;
      if (mode == MODE_DIV && num >= {den, {DutyBits{1'b0}}}) begin
        mode <= MODE_FULL;
      end
    end
    if (cmd.step) begin
      rem <= rem_ge ? rem_diff[WidthBits-1:0] : rem_sh[WidthBits-1:0];
      num_lo <= {num_lo[DutyBits-2:0], 1'b0};
      quot <= {quot[DutyBits-2:0], rem_ge};
    end
    if (cmd.store) begin
      if (cmd.ch) begin
        res.right_fwd_duty <= dir_fwd ? duty : DUTY_ZERO;
        res.right_rev_duty <= dir_fwd ? DUTY_ZERO : duty;
      end else begin
        res.left_fwd_duty <= dir_fwd ? duty : DUTY_ZERO;
        res.left_rev_duty <= dir_fwd ? DUTY_ZERO : duty;
      end
    end
    if (cmd.publish) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.publish || (result_valid && result_stall);
    end
  end

endmodule

FILE: design/rc_pulse_to_bridge_drive.sv
// Top level of the RC pulse to bridge drive block.
// Joins the controller and the datapath; depends on rcpb_pkg, rcpb_ctrl and rcpb_datapath.
//
// The item channel (item_valid, item_stall, item) carries one sample of the left and
// right servo pulse levels per microsecond tick. A transfer happens on a rising edge
// of clk with item_valid high and item_stall low. Each accepted item yields exactly
// one result on the result channel (result_valid, result_stall, result) holding the
// forward and reverse duties of both motors, computed from the pulse widths after
// that item.
// After its transfer, each item is processed in full before the block takes the next item:
// one shared 8-step restoring divider serves the left channel and then the right, with
// a setup and a load state before and a store state after each division. The result is
// then registered into the output register once both divisions are stored.
// The result sits in an output register. A stalled result waits there; the next item is
// still taken, but its result and the item after it wait until the old result moves out.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
// make them only while no item is in flight, as the block itself does not enforce it.
// Reset clears the pulse trackers, sets both latched widths to 1500, loads the register
// defaults and empties the output register.
module rc_pulse_to_bridge_drive (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [rcpb_pkg::WidthBits-1:0] cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  rcpb_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output rcpb_pkg::result_t              result
);
  import rcpb_pkg::*;

  cmd_t cmd;
  status_t status;

  rcpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rcpb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(result_valid && result_stall))
    else $error("A new result would overwrite a stalled result.");

  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("The block took no time to process an accepted item.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.publish))
    else $error("A result appeared without being computed.");

endmodule

FILE: tb/tb_rc_pulse_to_bridge_drive.sv
// Self-checking testbench for rc_pulse_to_bridge_drive: drives pulse-level samples and
// checks every duty result against an in-bench predictor of the trackers and duty mapping.
// Depends on rcpb_pkg and the rc_pulse_to_bridge_drive RTL.
module tb_rc_pulse_to_bridge_drive;
  import rcpb_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned DrainCycles = 30;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [WidthBits-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;

  logic [WidthBits-1:0] neutral_set = NEUTRAL_RESET;
  logic [WidthBits-1:0] deadband_set = DEADBAND_RESET;
  logic [WidthBits-1:0] max_set = MAX_RESET;
  logic [WidthBits-1:0] min_set = MIN_RESET;
  logic prev_level [2] = '{1'b0, 1'b0};
  logic [WidthBits-1:0] pulse_count [2] = '{16'd0, 16'd0};
  logic [WidthBits-1:0] held_width [2] = '{WIDTH_RESET, WIDTH_RESET};

  result_t duty_q[$];
  bit idle_on;
  int error_count;
  int ticks_sent;
  int results_checked;
  int settings_used;

  rc_pulse_to_bridge_drive u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [DutyBits-1:0] scaled_duty(input longint num, input longint den);
    longint q;
    longint full;
    full = DUTY_FULL;
    if (den == 0) begin
      return DUTY_FULL;
    end
    q = num / den;
    if (q < 0) begin
      return DUTY_ZERO;
    end
    if (q > full) begin
      return DUTY_FULL;
    end
    return q[DutyBits-1:0];
  endfunction

  function automatic void map_duty(input logic [WidthBits-1:0] w,
                                   output logic [DutyBits-1:0] fwd,
                                   output logic [DutyBits-1:0] rev);
    longint x;
    longint up;
    longint dn;
    longint full;
    full = DUTY_FULL;
    x = w;
    up = longint'(neutral_set) + longint'(deadband_set);
    dn = longint'(neutral_set) - longint'(deadband_set);
    fwd = DUTY_ZERO;
    rev = DUTY_ZERO;
    if (x > up) begin
      fwd = scaled_duty((x - up) * full, longint'(max_set) - up);
    end else if (x < dn) begin
      rev = scaled_duty((x - dn) * full, longint'(min_set) - dn);
    end
  endfunction

  function automatic void advance_tracker(input int ch, input logic level);
    if (level && !prev_level[ch]) begin
      pulse_count[ch] = '0;
    end else begin
      if (pulse_count[ch] != COUNT_MAX) begin
        pulse_count[ch] = pulse_count[ch] + 1'b1;
      end
      if (!level && prev_level[ch]) begin
        held_width[ch] = pulse_count[ch];
      end
    end
    prev_level[ch] = level;
  endfunction

  function automatic result_t predict_duties(input item_t it);
    result_t r;
    advance_tracker(0, it.left_level);
    advance_tracker(1, it.right_level);
    map_duty(held_width[0], r.left_fwd_duty, r.left_rev_duty);
    map_duty(held_width[1], r.right_fwd_duty, r.right_rev_duty);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_checked);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (duty_q.size() == 0) begin
        report_mismatch("unexpected result", result, 0);
      end else begin
        want = duty_q.pop_front();
        if (result.left_fwd_duty != want.left_fwd_duty) begin
          report_mismatch("left_fwd_duty", result.left_fwd_duty, want.left_fwd_duty);
        end
        if (result.left_rev_duty != want.left_rev_duty) begin
          report_mismatch("left_rev_duty", result.left_rev_duty, want.left_rev_duty);
        end
        if (result.right_fwd_duty != want.right_fwd_duty) begin
          report_mismatch("right_fwd_duty", result.right_fwd_duty, want.right_fwd_duty);
        end
        if (result.right_rev_duty != want.right_rev_duty) begin
          report_mismatch("right_rev_duty", result.right_rev_duty, want.right_rev_duty);
        end
      end
      results_checked++;
    end
  end

  // The receiver holds off the result channel in short random bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(input item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    duty_q.push_back(predict_duties(it));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (duty_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [WidthBits-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_NEUTRAL: neutral_set = value;
      REG_DEADBAND: deadband_set = value;
      REG_MAX: max_set = value;
      REG_MIN: min_set = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [WidthBits-1:0] neutral,
                                input logic [WidthBits-1:0] deadband,
                                input logic [WidthBits-1:0] full_fwd,
                                input logic [WidthBits-1:0] full_rev);
    write_reg(REG_NEUTRAL, neutral);
    write_reg(REG_DEADBAND, deadband);
    write_reg(REG_MAX, full_fwd);
    write_reg(REG_MIN, full_rev);
    settings_used++;
  endtask

  // Both channels rise together; each stays high for its own count of ticks.
  task automatic send_pulse_pair(input int left_high, input int right_high, input int low_ticks);
    int span;
    span = (left_high > right_high ? left_high : right_high) + low_ticks;
    for (int i = 0; i < span; i++) begin
      send_tick(item_t'{left_level: i < left_high, right_level: i < right_high});
    end
  endtask

  task automatic test_reset_state();
    for (int i = 0; i < 3; i++) begin
      send_tick(item_t'{left_level: 1'b0, right_level: 1'b0});
    end
    wait_drained();
  endtask

  task automatic test_edge_widths();
    set_thresholds(16'd4, 16'd1, 16'd8, 16'd1);
    send_pulse_pair(1, 8, 1);
    send_pulse_pair(4, 6, 1);
    send_pulse_pair(2, 9, 1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    logic [WidthBits-1:0] corner [7][4];
    corner = '{
      '{16'd0, 16'd0, 16'd0, 16'd0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF},
      '{16'hFFFF, 16'd0, 16'd0, 16'd0},
      '{16'd4, 16'd0, 16'd2, 16'd6},
      '{16'd0, 16'd10, 16'd20, 16'd0},
      '{16'd1, 16'd0, 16'd1, 16'd1}
    };
    foreach (corner[k]) begin
      set_thresholds(corner[k][0], corner[k][1], corner[k][2], corner[k][3]);
      send_tick(item_t'{left_level: 1'b0, right_level: 1'b0});
      wait_drained();
    end
  endtask

  task automatic test_wide_thresholds();
    logic [WidthBits-1:0] corner [5][4];
    corner = '{
      '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF},
      '{16'd0, 16'd0, 16'hFFFF, 16'd0},
      '{16'd60000, 16'd0, 16'd0, 16'd0},
      '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0},
      '{16'd32768, 16'd100, 16'hFFFF, 16'hFFFF}
    };
    idle_on = 1'b0;
    foreach (corner[k]) begin
      set_thresholds(corner[k][0], corner[k][1], corner[k][2], corner[k][3]);
      repeat (3) send_tick(item_t'{left_level: 1'b0, right_level: 1'b0});
      wait_drained();
    end
    idle_on = 1'b1;
  endtask

  function automatic logic [WidthBits-1:0] pick_setting(input int lo, input int hi);
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
    end
    return WidthBits'($urandom_range(lo, hi));
  endfunction

  task automatic test_random_traffic();
    int remaining [2];
    logic level [2];
    item_t it;
    bit noisy;
    for (int phase = 0; phase < 9; phase++) begin
      idle_on = (phase < 7);
      noisy = (phase % 4 == 3);
      set_thresholds(pick_setting(5, 70), pick_setting(0, 12), pick_setting(0, 140),
                     pick_setting(0, 60));
      remaining = '{0, 0};
      level = '{1'b0, 1'b0};
      for (int t = 0; t < 150; t++) begin
        if (noisy) begin
          it = item_t'(2'($urandom_range(0, 3)));
        end else begin
          for (int ch = 0; ch < 2; ch++) begin
            if (remaining[ch] == 0) begin
              level[ch] = !level[ch];
              if (!level[ch]) begin
                remaining[ch] = $urandom_range(1, 12);
              end else if ($urandom_range(0, 9) == 0) begin
                remaining[ch] = $urandom_range(100, 300);
              end else begin
                remaining[ch] = $urandom_range(1, 90);
              end
            end
            remaining[ch]--;
          end
          it = item_t'{left_level: level[0], right_level: level[1]};
        end
        send_tick(it);
      end
      wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_NEUTRAL;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    idle_on = 1'b1;
    error_count = 0;
    ticks_sent = 0;
    results_checked = 0;
    settings_used = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_edge_widths();
    test_register_extremes();
    test_wide_thresholds();
    test_random_traffic();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (duty_q.size() != 0) begin
      report_mismatch("results never delivered", 0, duty_q.size());
    end
    $display("Sent %0d pulse samples and checked %0d duty results over %0d threshold settings,",
             ticks_sent, results_checked, settings_used);
    $display("including register extremes, wide threshold sums and random stalls on both sides.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
